// ===== hw/rtl/itra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itra_pkg: shared definitions for the integer to radix ASCII converter
// Field widths, character codes, the per-item flag bundle that crosses the
// item queue, and the digit-to-character lookup.
// ----------------------------------------------------------------------------
package itra_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int VALUE_IN_W = 32;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_F_UP  = 8'h46;
	localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_F_LO  = 8'h66;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// Per-item control bundle handed from the front end to the back end.
	typedef struct packed {
		logic               neg;
		logic               upper;
		logic [RADIX_W-1:0] radix;
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base;
		begin
			if (d < DIGIT_W'(10)) begin
				digit_char = CHAR_ZERO + CHAR_W'(d);
			end else begin
				base = upper ? CHAR_A_UP : CHAR_A_LO;
				digit_char = base + CHAR_W'(d) - CHAR_W'(10);
			end
		end
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/itra_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itra_front: item classifier
// Clamps the radix into range, decides whether the value is negative in
// signed mode and forms the unsigned magnitude that the back end converts.
// ----------------------------------------------------------------------------
module itra_front #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic [itra_pkg::VALUE_IN_W-1:0] value,
	input  wire logic [itra_pkg::RADIX_W-1:0]    radix,
	input  wire logic                            mode,
	input  wire logic                            upper_case,
	output      itra_pkg::item_flags_t           flags,
	output      logic [VALUE_WIDTH-1:0]          mag
);
	import itra_pkg::*;

	logic [VALUE_WIDTH-1:0] word;
	logic                   neg;

	always_comb begin
		word = VALUE_WIDTH'(value);
		neg  = mode & word[VALUE_WIDTH-1];
		// Two's complement negate; the most negative word maps onto itself,
		// which read unsigned is exactly its magnitude.
		mag  = neg ? (~word + VALUE_WIDTH'(1)) : word;

		flags.neg   = neg;
		flags.upper = upper_case;
		priority if (radix < RADIX_MIN) begin
			flags.radix = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			flags.radix = RADIX_MAX;
		end else begin
			flags.radix = radix;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/itra_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itra_queue: short item queue
// A small first-in first-out buffer that decouples the accepting front end
// from the converting back end.
// ----------------------------------------------------------------------------
module itra_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = itra_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output      logic              full,
	input  wire logic              pop,
	output      logic [DATA_W-1:0] pop_data,
	output      logic              empty
);
	import itra_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/itra_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itra_back: digit generator and character emitter
// Repeatedly divides the magnitude by the radix, eight quotient bits per
// cycle, stores the remainders, then emits the sign and the digits from the
// most significant one down.
// ----------------------------------------------------------------------------
module itra_back #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	output      logic                         q_pop,
	input  wire itra_pkg::item_flags_t        q_flags,
	input  wire logic [VALUE_WIDTH-1:0]       q_mag,
	output      logic                         valid,
	output      logic [itra_pkg::CHAR_W-1:0]  character,
	output      logic                         last
);
	import itra_pkg::*;

	localparam int BITS_PER_CYC = 8;
	localparam int NCHUNK       = (VALUE_WIDTH + BITS_PER_CYC - 1) / BITS_PER_CYC;
	localparam int DIV_W        = NCHUNK * BITS_PER_CYC;
	localparam int CNT_W        = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int AW           = $clog2(VALUE_WIDTH);
	localparam int NDIG_W       = $clog2(VALUE_WIDTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NDIG_W-1:0]  ndig_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               rd_v_s1;
	logic               rd_last_s1;
	logic               valid_q;

	logic [DIV_W-1:0]   div_q;
	logic [DIGIT_W-1:0] rem_q;
	item_flags_t        flags_q;
	logic [DIGIT_W-1:0] rd_data_s1;
	logic [CHAR_W-1:0]  character_q;
	logic               last_q;
	logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

	logic [DIV_W-1:0]   d_next;
	logic [DIGIT_W-1:0] r_next;
	logic               chunk_last;
	logic               quot_zero;

	// Restoring division, one quotient bit per step, eight steps per cycle.
	// The quotient bits shift into the vacated low end of the dividend.
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		logic [DIV_W-1:0]   d;
		r = rem_q;
		d = div_q;
		for (int i = 0; i < BITS_PER_CYC; i++) begin
			t = {r, d[DIV_W-1]};
			d = {d[DIV_W-2:0], 1'b0};
			if (t >= flags_q.radix) begin
				t    = t - flags_q.radix;
				d[0] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		d_next = d;
		r_next = r;
	end

	assign chunk_last = (cnt_q == CNT_W'(NCHUNK - 1));
	assign quot_zero  = (d_next == '0);
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ndig_q   <= '0;
			rd_ptr_q <= '0;
			rd_v_s1  <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_EMIT);
			valid_q <= (state_q == ST_SIGN) || rd_v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= '0;
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (chunk_last) begin
						cnt_q    <= '0;
						ndig_q   <= ndig_q + NDIG_W'(1);
						rd_ptr_q <= ndig_q[AW-1:0];
						if (quot_zero) begin
							state_q <= flags_q.neg ? ST_SIGN : ST_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SIGN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (rd_ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_ptr_q <= rd_ptr_q - AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			div_q   <= DIV_W'(q_mag);
			rem_q   <= '0;
			flags_q <= q_flags;
		end else if (state_q == ST_DIV) begin
			div_q <= d_next;
			rem_q <= chunk_last ? '0 : r_next;
		end
		if ((state_q == ST_DIV) && chunk_last) begin
			digit_mem[ndig_q[AW-1:0]] <= r_next;
		end
		if (state_q == ST_EMIT) begin
			rd_data_s1 <= digit_mem[rd_ptr_q];
			rd_last_s1 <= (rd_ptr_q == '0);
		end
		if (state_q == ST_SIGN) begin
			character_q <= CHAR_MINUS;
			last_q      <= 1'b0;
		end else if (rd_v_s1) begin
			character_q <= digit_char(rd_data_s1, flags_q.upper);
			last_q      <= rd_last_s1;
		end
	end

	assign valid     = valid_q;
	assign character = character_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/integer_to_radix_ascii_core.sv =====
`default_nettype none
// From the cycle in which an item leaves the queue, the back end divides it down to its digits,
// then plays out the sign, if any, and the digits; it takes the next item only after reading
// out the last digit. The divider retires eight quotient bits per cycle.
// Reset: arst_n clears the queue and control state. The receiver cannot stall.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core: integer to ASCII digits in radix 2 to 16
// Converts one word per command into a stream of character beats, most
// significant digit first, with an optional leading minus sign.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core #(
	parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = itra_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire logic [itra_pkg::VALUE_IN_W-1:0] value,
	input  wire logic [itra_pkg::RADIX_W-1:0]    radix,
	input  wire logic                            mode,
	input  wire logic                            upper_case,
	output      logic                            valid,
	output      logic [itra_pkg::CHAR_W-1:0]     character,
	output      logic                            last
);
	import itra_pkg::*;

	// One queue entry carries the classified flags above the magnitude.
	localparam int QW = FLAGS_W + VALUE_WIDTH;

	item_flags_t            front_flags;
	logic [VALUE_WIDTH-1:0] front_mag;
	logic                   q_push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_empty;
	logic [QW-1:0]          q_out;
	item_flags_t            q_flags;
	logic [VALUE_WIDTH-1:0] q_mag;

	// The front end is pure classification; an item is taken whenever the
	// queue has room, so busy is simply the queue being full.
	itra_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.value      (value),
		.radix      (radix),
		.mode       (mode),
		.upper_case (upper_case),
		.flags      (front_flags),
		.mag        (front_mag)
	);

	assign q_push = start && !q_full;
	assign busy   = q_full;

	itra_queue #(
		.DATA_W(QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({front_flags, front_mag}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign q_flags = item_flags_t'(q_out[QW-1:VALUE_WIDTH]);
	assign q_mag   = q_out[VALUE_WIDTH-1:0];

	// The back end pulls one item at a time, divides it down into digits and
	// plays them out, one beat per cycle after the sign.
	itra_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_flags   (q_flags),
		.q_mag     (q_mag),
		.valid     (valid),
		.character (character),
		.last      (last)
	);

	// The sign is never the final character of a number.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (character == CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as last character");

	// After the sign a gap follows, since the digit memory read is registered.
	a_gap_after_minus: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (character == CHAR_MINUS) |=> !valid)
		else $error("beat directly after minus sign");

	// Every beat is a minus sign or a legal digit character.
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (character == CHAR_MINUS)
			|| ((character >= CHAR_ZERO) && (character <= CHAR_NINE))
			|| ((character >= CHAR_A_UP) && (character <= CHAR_F_UP))
			|| ((character >= CHAR_A_LO) && (character <= CHAR_F_LO)))
		else $error("illegal character beat");

	// The back end never takes an item from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty item queue");

endmodule
`default_nettype wire

// ===== dv/integer_to_radix_ascii_core_test.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core_test: self-checking bench for the radix converter
// Drives conversion commands through the start/busy handshake and checks every
// character beat against typed-in answers or an in-bench digit expansion:
// a short table of edge cases first, then several hundred randomized commands.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core_test;
	import itra_pkg::*;

	// A watchdog ends the run after this many cycles with nothing accepted on
	// either side. The limit lies far above the divide of the longest item, and
	// a queued command may wait behind two others, so this is several times over.
	localparam int STALL_LIMIT   = 2000;
	// Cycles to keep watching after the last expected beat, for stray beats.
	localparam int DRAIN_CYCLES  = 200;
	localparam int RANDOM_ITEMS  = 420;
	localparam int NUM_DIRECTED  = 25;
	localparam int TEXT_CHARS    = 33;

	// One directed command. A non-zero text holds the exact characters that
	// the command must produce; a zero text leaves the answer to the model.
	typedef struct packed {
		logic [VALUE_IN_W-1:0]       value;
		logic [RADIX_W-1:0]          radix;
		logic                        mode;
		logic                        upper;
		logic [8*TEXT_CHARS-1:0]     text;
	} conversion_case_t;

	// One expected character beat.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [VALUE_IN_W-1:0] value = '0;
	logic [RADIX_W-1:0]    radix = RADIX_MIN;
	logic                  mode = 1'b0;
	logic                  upper_case = 1'b0;
	logic                  valid;
	logic [CHAR_W-1:0]     character;
	logic                  last;

	// Index of the directed row on the command ports, or -1 for a random one.
	// It travels with the command fields so the monitor knows which to use.
	int                    case_row = -1;

	char_beat_t            expected_chars[$];
	int                    mismatches = 0;
	int                    stall_cycles = 0;

	conversion_case_t conversion_cases [NUM_DIRECTED] = '{
		// Zero straight after reset, in both modes: a lone '0', never a sign.
		'{32'h0000_0000, 5'd10, 1'b0, 1'b0, "0"},
		'{32'h0000_0000, 5'd10, 1'b1, 1'b0, "0"},
		// All ones, unsigned, in the smallest and largest bases and in ten.
		'{32'hFFFF_FFFF, 5'd2,  1'b0, 1'b0, "11111111111111111111111111111111"},
		'{32'hFFFF_FFFF, 5'd16, 1'b0, 1'b0, "ffffffff"},
		'{32'hFFFF_FFFF, 5'd16, 1'b0, 1'b1, "FFFFFFFF"},
		'{32'hFFFF_FFFF, 5'd10, 1'b0, 1'b0, "4294967295"},
		// Signed extremes; the most negative word in base 2 is the longest
		// possible output, a sign plus 32 digits.
		'{32'hFFFF_FFFF, 5'd10, 1'b1, 1'b0, "-1"},
		'{32'h8000_0000, 5'd10, 1'b1, 1'b0, "-2147483648"},
		'{32'h8000_0000, 5'd2,  1'b1, 1'b0, "-10000000000000000000000000000000"},
		'{32'h8000_0000, 5'd16, 1'b1, 1'b1, "-80000000"},
		'{32'h7FFF_FFFF, 5'd10, 1'b1, 1'b0, "2147483647"},
		// Out-of-range bases saturate to two and to sixteen.
		'{32'h0000_0005, 5'd0,  1'b0, 1'b0, "101"},
		'{32'h0000_0005, 5'd1,  1'b0, 1'b0, "101"},
		'{32'h0000_00FF, 5'd17, 1'b0, 1'b0, "ff"},
		'{32'h0000_00FF, 5'd31, 1'b0, 1'b1, "FF"},
		'{32'h0000_0001, 5'd2,  1'b0, 1'b0, "1"},
		// Letter case on every letter digit.
		'{32'h00AB_CDEF, 5'd16, 1'b0, 1'b0, "abcdef"},
		'{32'h00AB_CDEF, 5'd16, 1'b0, 1'b1, "ABCDEF"},
		'{32'hFFFF_FFF6, 5'd10, 1'b1, 1'b1, "-10"},
		// A sign in a base other than ten, and a few odd bases.
		'{32'hFFFF_FFFF, 5'd15, 1'b1, 1'b1, "-1"},
		'{32'h00BC_614E, 5'd7,  1'b0, 1'b0, '0},
		'{32'hDEAD_BEEF, 5'd13, 1'b1, 1'b1, '0},
		'{32'h0000_0010, 5'd3,  1'b1, 1'b0, '0},
		'{32'h8000_0000, 5'd11, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 5'd31, 1'b1, 1'b1, "0"}
	};

	integer_to_radix_ascii_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.radix      (radix),
		.mode       (mode),
		.upper_case (upper_case),
		.valid      (valid),
		.character  (character),
		.last       (last)
	);

	always #5 clk = ~clk;

	// Expands one command into its character beats, most significant digit
	// first. The magnitude is taken as an unsigned 32-bit quantity, so the
	// most negative word negates to itself and still converts correctly.
	function automatic void push_ascii_digits(input logic [VALUE_IN_W-1:0] v,
			input logic [RADIX_W-1:0] r, input logic m, input logic u);
		logic [VALUE_IN_W-1:0] base;
		logic [VALUE_IN_W-1:0] mag;
		logic [DIGIT_W-1:0]    rev [VALUE_IN_W];
		logic [CHAR_W-1:0]     c;
		logic                  neg;
		int                    n;
		base = (r < RADIX_MIN) ? VALUE_IN_W'(RADIX_MIN) :
			(r > RADIX_MAX) ? VALUE_IN_W'(RADIX_MAX) : VALUE_IN_W'(r);
		if (v == '0) begin
			expected_chars.push_back('{CHAR_ZERO, 1'b1});
			return;
		end
		neg = m && v[VALUE_IN_W-1];
		mag = neg ? -v : v;
		n = 0;
		while (mag != '0) begin
			rev[n] = DIGIT_W'(mag % base);
			mag = mag / base;
			n++;
		end
		if (neg) begin
			expected_chars.push_back('{CHAR_MINUS, 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			if (rev[i] < 10) begin
				c = CHAR_ZERO + CHAR_W'(rev[i]);
			end else begin
				c = (u ? CHAR_A_UP : CHAR_A_LO) + CHAR_W'(rev[i]) - CHAR_W'(10);
			end
			expected_chars.push_back('{c, i == 0});
		end
	endfunction

	// Queues the characters of a typed-in answer. The text is right-aligned
	// in its field, so leading zero bytes are padding and are skipped.
	function automatic void push_text(input logic [8*TEXT_CHARS-1:0] t);
		logic [CHAR_W-1:0] c;
		for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
			c = t[i*8 +: 8];
			if (c != '0) begin
				expected_chars.push_back('{c, 1'b0});
			end
		end
		expected_chars[expected_chars.size()-1].last = 1'b1;
	endfunction

	// Monitor. Everything is sampled at the rising edge, before any of this
	// edge's nonblocking updates land, so the bench and the block agree on
	// which beats were accepted.
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n) begin
			// A character beat is taken by the receiver every cycle it is shown.
			if (valid) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got char %h last %b",
						$time, character, last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.ch) begin
						$display("%0t: character expected %h got %h",
							$time, want.ch, character);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b got %b", $time, want.last, last);
						mismatches++;
					end
				end
			end
			// A command beat is accepted when start meets a free block.
			if (start && !busy) begin
				if (case_row >= 0 && conversion_cases[case_row].text != '0) begin
					push_text(conversion_cases[case_row].text);
				end else begin
					push_ascii_digits(value, radix, mode, upper_case);
				end
			end
			if ((start && !busy) || valid) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Presents one command after an idle gap and returns at the edge where it
	// is accepted. With no gap the start line simply stays high, so it is
	// never lowered and raised in the same step.
	task automatic send_command(input logic [VALUE_IN_W-1:0] v, input logic [RADIX_W-1:0] r,
			input logic m, input logic u, input int row, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		value      <= v;
		radix      <= r;
		mode       <= m;
		upper_case <= u;
		case_row   <= row;
		do begin
			@(posedge clk);
		end while (!(start && !busy));
	endtask

	// Random word with a bias toward short outputs, sign boundaries and
	// single set bits; full-width words still make up a good share.
	function automatic logic [VALUE_IN_W-1:0] random_word();
		logic [VALUE_IN_W-1:0] w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = $urandom;
			4, 5:       w = $urandom_range(0, 1000);
			6:          w = -VALUE_IN_W'($urandom_range(1, 1000));
			7:          w = VALUE_IN_W'(1) << $urandom_range(0, VALUE_IN_W - 1);
			8: begin
				case ($urandom_range(0, 3))
					0:       w = 32'h0000_0000;
					1:       w = 32'h8000_0000;
					2:       w = 32'h7FFF_FFFF;
					default: w = 32'hFFFF_FFFF;
				endcase
			end
			default:    w = $urandom >> $urandom_range(0, VALUE_IN_W - 1);
		endcase
		return w;
	endfunction

	initial begin
		logic [RADIX_W-1:0] r;
		bit                 no_idle;
		int                 gap;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_command(conversion_cases[i].value, conversion_cases[i].radix,
				conversion_cases[i].mode, conversion_cases[i].upper, i,
				$urandom_range(0, 10));
		end

		// Random part: mostly legal bases, now and then any 5-bit code so the
		// saturation on both sides keeps getting hit. Runs of back-to-back
		// commands alternate with runs of random idle gaps.
		no_idle = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 30 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			gap = no_idle ? 0 : $urandom_range(0, 10);
			r = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 31)) :
				RADIX_W'($urandom_range(2, 16));
			send_command(random_word(), r, 1'(($urandom_range(0, 1))),
				1'(($urandom_range(0, 1))), -1, gap);
		end
		start <= 1'b0;

		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, expected_chars.size());
		end
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/itra_pkg.sv
hw/rtl/itra_front.sv
hw/rtl/itra_queue.sv
hw/rtl/itra_back.sv
hw/rtl/integer_to_radix_ascii_core.sv
dv/integer_to_radix_ascii_core_test.sv
